// ===== hw/rtl/ithp_pkg.sv =====
// Shared constants and types for the IP transport header parser.
package ithp_pkg;

  localparam logic [15:0] LINK_HEADER_BYTES = 16'd14;

  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_ICMP6  = 8'd58;
  localparam logic [7:0] NH_FRAG      = 8'd44;
  localparam logic [7:0] NH_ESP       = 8'd50;
  localparam logic [7:0] NH_NONE      = 8'd59;

  localparam logic [3:0] VER_4 = 4'd4;
  localparam logic [3:0] VER_6 = 4'd6;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_BADVER = 2'd2;
  localparam logic [1:0] ST_TRUNC  = 2'd3;

  typedef enum logic [11:0] {
    PH_LINK   = 12'b0000_0000_0001,
    PH_V4HDR  = 12'b0000_0000_0010,
    PH_V6HDR  = 12'b0000_0000_0100,
    PH_V6ADDR = 12'b0000_0000_1000,
    PH_SKIP   = 12'b0000_0001_0000,
    PH_EXT    = 12'b0000_0010_0000,
    PH_TCP    = 12'b0000_0100_0000,
    PH_UDP    = 12'b0000_1000_0000,
    PH_ICMP   = 12'b0001_0000_0000,
    PH_OK     = 12'b0010_0000_0000,
    PH_NONE   = 12'b0100_0000_0000,
    PH_BADVER = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0]  parse_status;
    logic [3:0]  ip_version;
    logic [7:0]  protocol;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [63:0] seq_ack;
    logic [21:0] transport_info;
    logic [15:0] ip_total_length;
  } result_t;

endpackage

// ===== hw/rtl/ithp_core.sv =====
// Byte-at-a-time header parse state and result assembly.
module ithp_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 link_type,
  input  logic                 byte_vld,
  input  logic [7:0]           byte_data,
  input  logic                 byte_last,
  input  logic                 res_stall,
  output logic                 res_vld,
  output ithp_pkg::result_t    res
);

  ithp_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] offs_r, offs_nxt;
  logic [3:0]  ihl_r, ihl_nxt;
  logic [7:0]  nh_r, nh_nxt;
  logic [11:0] skip_r, skip_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [63:0] src0_r, src0_nxt, src1_r, src1_nxt;
  logic [63:0] dst0_r, dst0_nxt, dst1_r, dst1_nxt;
  logic [63:0] tf0_r, tf0_nxt, tf1_r, tf1_nxt, tf2_r, tf2_nxt;
  logic [3:0]  ver_r, ver_nxt;
  logic [15:0] len_r, len_nxt;
  logic [11:0] skip_dec;
  logic [11:0] ext_len;

  function automatic ithp_pkg::phase_t dispatch(input logic [3:0] ver, input logic [7:0] nh);
    ithp_pkg::phase_t ph;
    if (nh == ithp_pkg::PROTO_TCP) ph = ithp_pkg::PH_TCP;
    else if (nh == ithp_pkg::PROTO_UDP) ph = ithp_pkg::PH_UDP;
    else if ((ver == ithp_pkg::VER_4 && nh == ithp_pkg::PROTO_ICMP) ||
             (ver == ithp_pkg::VER_6 && nh == ithp_pkg::PROTO_ICMP6)) ph = ithp_pkg::PH_ICMP;
    else if (ver == ithp_pkg::VER_4 || nh == ithp_pkg::NH_FRAG || nh == ithp_pkg::NH_ESP ||
             nh == ithp_pkg::NH_NONE) ph = ithp_pkg::PH_NONE;
    else ph = ithp_pkg::PH_EXT;
    return ph;
  endfunction

  assign skip_dec = (skip_r != 12'd0) ? skip_r - 12'd1 : skip_r;
  assign ext_len  = {1'b0, byte_data, 3'b000} + 12'd6;

  always_comb begin
    phase_nxt = phase_r;
    offs_nxt  = offs_r;
    ihl_nxt   = ihl_r;
    nh_nxt    = nh_r;
    skip_nxt  = skip_r;
    idx_nxt   = idx_r;
    src0_nxt  = src0_r;
    src1_nxt  = src1_r;
    dst0_nxt  = dst0_r;
    dst1_nxt  = dst1_r;
    tf0_nxt   = tf0_r;
    tf1_nxt   = tf1_r;
    tf2_nxt   = tf2_r;
    ver_nxt   = ver_r;
    len_nxt   = len_r;
    unique case (phase_r)
      ithp_pkg::PH_LINK: begin
        if (!(link_type == 1'b0 && offs_r < ithp_pkg::LINK_HEADER_BYTES)) begin
          ver_nxt = byte_data[7:4];
          len_nxt = 16'd0;
          idx_nxt = 5'd1;
          if (byte_data[7:4] == ithp_pkg::VER_4) begin
            ihl_nxt   = byte_data[3:0];
            phase_nxt = ithp_pkg::PH_V4HDR;
          end else if (byte_data[7:4] == ithp_pkg::VER_6) begin
            phase_nxt = ithp_pkg::PH_V6HDR;
          end else begin
            phase_nxt = ithp_pkg::PH_BADVER;
          end
        end
      end
      ithp_pkg::PH_V4HDR: begin
        if (idx_r == 5'd2 || idx_r == 5'd3) len_nxt = {len_r[7:0], byte_data};
        else if (idx_r == 5'd9) nh_nxt = byte_data;
        else if (idx_r >= 5'd12 && idx_r <= 5'd15) src1_nxt = {32'd0, src1_r[23:0], byte_data};
        else if (idx_r >= 5'd16) dst1_nxt = {32'd0, dst1_r[23:0], byte_data};
        if (idx_r >= 5'd19) begin
          if (ihl_r > 4'd5) begin
            skip_nxt  = {6'd0, ihl_r - 4'd5, 2'b00};
            phase_nxt = ithp_pkg::PH_SKIP;
          end else begin
            idx_nxt   = 5'd0;
            phase_nxt = dispatch(ver_r, nh_r);
          end
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end
      ithp_pkg::PH_V6HDR: begin
        if (idx_r == 5'd4 || idx_r == 5'd5) len_nxt = {len_r[7:0], byte_data};
        else if (idx_r == 5'd6) nh_nxt = byte_data;
        if (idx_r >= 5'd7) begin
          idx_nxt   = 5'd0;
          phase_nxt = ithp_pkg::PH_V6ADDR;
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end
      ithp_pkg::PH_V6ADDR: begin
        unique case (idx_r[4:3])
          2'd0:    src0_nxt = {src0_r[55:0], byte_data};
          2'd1:    src1_nxt = {src1_r[55:0], byte_data};
          2'd2:    dst0_nxt = {dst0_r[55:0], byte_data};
          default: dst1_nxt = {dst1_r[55:0], byte_data};
        endcase
        if (idx_r == 5'd31) begin
          idx_nxt   = 5'd0;
          phase_nxt = dispatch(ver_r, nh_r);
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end
      ithp_pkg::PH_EXT: begin
        if (idx_r == 5'd0) begin
          nh_nxt  = byte_data;
          idx_nxt = 5'd1;
        end else begin
          skip_nxt  = ext_len;
          phase_nxt = ithp_pkg::PH_SKIP;
        end
      end
      ithp_pkg::PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == 12'd0) begin
          idx_nxt   = 5'd0;
          phase_nxt = dispatch(ver_r, nh_r);
        end
      end
      ithp_pkg::PH_TCP: begin
        if (idx_r < 5'd4) tf0_nxt = {32'd0, tf0_r[23:0], byte_data};
        else if (idx_r < 5'd12) tf1_nxt = {tf1_r[55:0], byte_data};
        else if (idx_r == 5'd13) tf2_nxt = {42'd0, byte_data[5:0], tf2_r[15:0]};
        else if (idx_r >= 5'd14) tf2_nxt = {tf2_r[63:16], tf2_r[7:0], byte_data};
        if (idx_r >= 5'd15) phase_nxt = ithp_pkg::PH_OK;
        else idx_nxt = idx_r + 5'd1;
      end
      ithp_pkg::PH_UDP: begin
        if (idx_r < 5'd4) tf0_nxt = {32'd0, tf0_r[23:0], byte_data};
        else tf2_nxt = {tf2_r[63:16], tf2_r[7:0], byte_data};
        if (idx_r >= 5'd5) phase_nxt = ithp_pkg::PH_OK;
        else idx_nxt = idx_r + 5'd1;
      end
      ithp_pkg::PH_ICMP: begin
        tf2_nxt = {tf2_r[63:16], tf2_r[7:0], byte_data};
        if (idx_r >= 5'd1) phase_nxt = ithp_pkg::PH_OK;
        else idx_nxt = idx_r + 5'd1;
      end
      default: ;
    endcase
    if (offs_r != 16'hFFFF) offs_nxt = offs_r + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld <= 1'b0;
    end else if (!res_stall) begin
      res_vld <= byte_vld && byte_last;
    end
    if (byte_vld && byte_last) begin
      priority case (phase_nxt)
        ithp_pkg::PH_OK:     res.parse_status <= ithp_pkg::ST_OK;
        ithp_pkg::PH_NONE:   res.parse_status <= ithp_pkg::ST_NONE;
        ithp_pkg::PH_BADVER: res.parse_status <= ithp_pkg::ST_BADVER;
        default:             res.parse_status <= ithp_pkg::ST_TRUNC;
      endcase
      res.ip_version      <= ver_nxt;
      res.protocol        <= nh_nxt;
      res.src_addr_hi     <= src0_nxt;
      res.src_addr_lo     <= src1_nxt;
      res.dst_addr_hi     <= dst0_nxt;
      res.dst_addr_lo     <= dst1_nxt;
      res.source_port     <= tf0_nxt[31:16];
      res.dest_port       <= tf0_nxt[15:0];
      res.seq_ack         <= tf1_nxt;
      res.transport_info  <= tf2_nxt[21:0];
      res.ip_total_length <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_vld && byte_last)) begin
      phase_r <= ithp_pkg::PH_LINK;
      offs_r  <= 16'd0;
      ihl_r   <= 4'd0;
      nh_r    <= 8'd0;
      skip_r  <= 12'd0;
      idx_r   <= 5'd0;
      src0_r  <= 64'd0;
      src1_r  <= 64'd0;
      dst0_r  <= 64'd0;
      dst1_r  <= 64'd0;
      tf0_r   <= 64'd0;
      tf1_r   <= 64'd0;
      tf2_r   <= 64'd0;
      ver_r   <= 4'd0;
      len_r   <= 16'd0;
    end else if (byte_vld) begin
      phase_r <= phase_nxt;
      offs_r  <= offs_nxt;
      ihl_r   <= ihl_nxt;
      nh_r    <= nh_nxt;
      skip_r  <= skip_nxt;
      idx_r   <= idx_nxt;
      src0_r  <= src0_nxt;
      src1_r  <= src1_nxt;
      dst0_r  <= dst0_nxt;
      dst1_r  <= dst1_nxt;
      tf0_r   <= tf0_nxt;
      tf1_r   <= tf1_nxt;
      tf2_r   <= tf2_nxt;
      ver_r   <= ver_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

// ===== hw/rtl/ip_transport_header_parser.sv =====
// Top level: input register, parse core and skid-buffered result output.
// An accepted last word reaches out_valid via the input, core result and output registers.
// Throughput: one word per cycle; in_stall rises only when the skid stage is full,
// and the input register and parse core hold while it is full.
// Reset: synchronous active-low rst_n clears parse state, the link type (to
// Ethernet) and all valid flags; no clearing pass.
module ip_transport_header_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   in_data_byte,
  input  logic         in_last_byte,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [1:0]   out_parse_status,
  output logic [3:0]   out_ip_version,
  output logic [7:0]   out_protocol,
  output logic [63:0]  out_src_addr_hi,
  output logic [63:0]  out_src_addr_lo,
  output logic [63:0]  out_dst_addr_hi,
  output logic [63:0]  out_dst_addr_lo,
  output logic [15:0]  out_source_port,
  output logic [15:0]  out_dest_port,
  output logic [63:0]  out_seq_ack,
  output logic [21:0]  out_transport_info,
  output logic [15:0]  out_ip_total_length
);

  logic              link_type_r;
  logic              ivld_r;
  logic [7:0]        ibyte_r;
  logic              ilast_r;
  logic              core_vld;
  logic              res_vld;
  ithp_pkg::result_t res;
  logic              ovld_r;
  ithp_pkg::result_t ores_r;
  logic              svld_r;
  ithp_pkg::result_t sres_r;
  logic              acc;

  assign in_stall = svld_r;
  assign acc      = in_valid && !in_stall;
  assign core_vld = ivld_r && !svld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_type_r <= 1'b0;
      ivld_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) link_type_r <= cfg_wr_data;
      if (!in_stall) ivld_r <= acc;
    end
    if (acc) begin
      ibyte_r <= in_data_byte;
      ilast_r <= in_last_byte;
    end
  end

  ithp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .link_type (link_type_r),
    .byte_vld  (core_vld),
    .byte_data (ibyte_r),
    .byte_last (ilast_r),
    .res_stall (svld_r),
    .res_vld   (res_vld),
    .res       (res)
  );

  // hold a result in the skid stage while the output is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
      svld_r <= 1'b0;
    end else begin
      if (!ovld_r || !out_stall) begin
        if (svld_r) begin
          ovld_r <= 1'b1;
          ores_r <= sres_r;
          svld_r <= 1'b0;
        end else begin
          ovld_r <= res_vld;
          ores_r <= res;
        end
      end else if (res_vld && !svld_r) begin
        svld_r <= 1'b1;
        sres_r <= res;
      end
    end
  end

  assign out_valid           = ovld_r;
  assign out_parse_status    = ores_r.parse_status;
  assign out_ip_version      = ores_r.ip_version;
  assign out_protocol        = ores_r.protocol;
  assign out_src_addr_hi     = ores_r.src_addr_hi;
  assign out_src_addr_lo     = ores_r.src_addr_lo;
  assign out_dst_addr_hi     = ores_r.dst_addr_hi;
  assign out_dst_addr_lo     = ores_r.dst_addr_lo;
  assign out_source_port     = ores_r.source_port;
  assign out_dest_port       = ores_r.dest_port;
  assign out_seq_ack         = ores_r.seq_ack;
  assign out_transport_info  = ores_r.transport_info;
  assign out_ip_total_length = ores_r.ip_total_length;

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for ip_transport_header_parser: packet streams checked against a behavioral parser.
`timescale 1ns / 1ps
module tb;

  typedef enum logic [3:0] {
    S_LINK, S_V4HDR, S_V6HDR, S_V6ADDR, S_SKIP, S_EXT, S_TCP, S_UDP, S_ICMP,
    S_OK, S_NONE, S_BADVER
  } pstate_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_data_byte = 8'd0;
  logic in_last_byte = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  wire ithp_pkg::result_t got;

  ip_transport_header_parser dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_parse_status(got.parse_status), .out_ip_version(got.ip_version),
    .out_protocol(got.protocol),
    .out_src_addr_hi(got.src_addr_hi), .out_src_addr_lo(got.src_addr_lo),
    .out_dst_addr_hi(got.dst_addr_hi), .out_dst_addr_lo(got.dst_addr_lo),
    .out_source_port(got.source_port), .out_dest_port(got.dest_port),
    .out_seq_ack(got.seq_ack), .out_transport_info(got.transport_info),
    .out_ip_total_length(got.ip_total_length)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parser copy
  logic        lt;
  logic [15:0] boff;
  pstate_t     ph;
  logic [3:0]  ihl;
  logic [7:0]  nhv;
  logic [15:0] skip;
  logic [4:0]  fidx;
  logic [63:0] sa [2];
  logic [63:0] da [2];
  logic [63:0] tf [3];
  logic [31:0] vpl;

  ithp_pkg::result_t headers_due[$];
  int errors = 0;
  int results_seen = 0;
  int bytes_sent = 0;
  int cycles = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit out_hold = 1'b0;

  task automatic clear_parse();
    boff = 0; ph = S_LINK; ihl = 0; nhv = 0; skip = 0; fidx = 0;
    sa[0] = 0; sa[1] = 0; da[0] = 0; da[1] = 0;
    tf[0] = 0; tf[1] = 0; tf[2] = 0; vpl = 0;
  endtask

  task automatic set_nh(logic [7:0] b);
    nhv = b;
    vpl = (vpl & 32'h0F00FFFF) | (32'(b) << 16);
  endtask

  task automatic shift_len(logic [7:0] b);
    vpl = (vpl & 32'h0FFF0000) | (((vpl << 8) | 32'(b)) & 32'hFFFF);
  endtask

  task automatic shift_info(logic [7:0] b);
    tf[2] = (tf[2] & ~64'hFFFF) | (((tf[2] << 8) | 64'(b)) & 64'hFFFF);
  endtask

  task automatic route_transport();
    logic [3:0] v;
    v = vpl[27:24];
    fidx = 0;
    if (nhv == ithp_pkg::PROTO_TCP) ph = S_TCP;
    else if (nhv == ithp_pkg::PROTO_UDP) ph = S_UDP;
    else if ((v == ithp_pkg::VER_4 && nhv == ithp_pkg::PROTO_ICMP) ||
             (v == ithp_pkg::VER_6 && nhv == ithp_pkg::PROTO_ICMP6))
      ph = S_ICMP;
    else if (v == ithp_pkg::VER_4 || nhv == ithp_pkg::NH_FRAG || nhv == ithp_pkg::NH_ESP ||
             nhv == ithp_pkg::NH_NONE) ph = S_NONE;
    else ph = S_EXT;
  endtask

  task automatic parse_byte(logic [7:0] b, logic last);
    int p;
    ithp_pkg::result_t r;
    p = fidx;
    case (ph)
      S_LINK: begin
        if (!(lt == 1'b0 && boff < ithp_pkg::LINK_HEADER_BYTES)) begin
          vpl = 32'(b[7:4]) << 24;
          fidx = 1;
          if (b[7:4] == ithp_pkg::VER_4) begin
            ihl = b[3:0]; ph = S_V4HDR;
          end else if (b[7:4] == ithp_pkg::VER_6) ph = S_V6HDR;
          else ph = S_BADVER;
        end
      end
      S_V4HDR: begin
        if (p == 2 || p == 3) shift_len(b);
        else if (p == 9) set_nh(b);
        else if (p >= 12 && p <= 15) sa[1] = ((sa[1] << 8) | 64'(b)) & 64'hFFFFFFFF;
        else if (p >= 16) da[1] = ((da[1] << 8) | 64'(b)) & 64'hFFFFFFFF;
        if (p >= 19) begin
          if (ihl > 5) begin
            skip = 16'((ihl - 5) * 4); ph = S_SKIP;
          end else route_transport();
        end else fidx = 5'(p + 1);
      end
      S_V6HDR: begin
        if (p == 4 || p == 5) shift_len(b);
        else if (p == 6) set_nh(b);
        if (p >= 7) begin
          fidx = 0; ph = S_V6ADDR;
        end else fidx = 5'(p + 1);
      end
      S_V6ADDR: begin
        if (p < 8) sa[0] = (sa[0] << 8) | 64'(b);
        else if (p < 16) sa[1] = (sa[1] << 8) | 64'(b);
        else if (p < 24) da[0] = (da[0] << 8) | 64'(b);
        else da[1] = (da[1] << 8) | 64'(b);
        if (p >= 31) route_transport();
        else fidx = 5'(p + 1);
      end
      S_EXT: begin
        if (p == 0) begin
          set_nh(b); fidx = 1;
        end else begin
          skip = 16'((int'(b) + 1) * 8 - 2); ph = S_SKIP;
        end
      end
      S_SKIP: begin
        if (skip > 0) skip--;
        if (skip == 0) route_transport();
      end
      S_TCP: begin
        if (p < 4) tf[0] = ((tf[0] << 8) | 64'(b)) & 64'hFFFFFFFF;
        else if (p < 12) tf[1] = (tf[1] << 8) | 64'(b);
        else if (p == 13) tf[2] = (tf[2] & 64'hFFFF) | (64'(b & 8'h3F) << 16);
        else if (p >= 14) shift_info(b);
        if (p >= 15) ph = S_OK;
        else fidx = 5'(p + 1);
      end
      S_UDP: begin
        if (p < 4) tf[0] = ((tf[0] << 8) | 64'(b)) & 64'hFFFFFFFF;
        else shift_info(b);
        if (p >= 5) ph = S_OK;
        else fidx = 5'(p + 1);
      end
      S_ICMP: begin
        shift_info(b);
        if (p >= 1) ph = S_OK;
        else fidx = 5'(p + 1);
      end
      default: ;
    endcase
    if (boff < 16'hFFFF) boff++;
    if (last) begin
      r.parse_status = (ph == S_OK) ? ithp_pkg::ST_OK : (ph == S_NONE) ? ithp_pkg::ST_NONE :
                       (ph == S_BADVER) ? ithp_pkg::ST_BADVER : ithp_pkg::ST_TRUNC;
      r.ip_version = vpl[27:24];
      r.protocol = nhv;
      r.src_addr_hi = sa[0];
      r.src_addr_lo = sa[1];
      r.dst_addr_hi = da[0];
      r.dst_addr_lo = da[1];
      r.source_port = tf[0][31:16];
      r.dest_port = tf[0][15:0];
      r.seq_ack = tf[1];
      r.transport_info = tf[2][21:0];
      r.ip_total_length = vpl[15:0];
      headers_due.push_back(r);
      clear_parse();
    end
  endtask

  task automatic report(string what, logic [63:0] g, logic [63:0] e);
    errors++;
    $display("mismatch %s: got %h expected %h (result %0d)", what, g, e, results_seen);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 50000) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver
  always @(posedge clk) begin
    ithp_pkg::result_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (headers_due.size() == 0) begin
        report("unexpected result", 64'(results_seen), 64'd0);
      end else begin
        e = headers_due.pop_front();
        if (got.parse_status !== e.parse_status)
          report("status", 64'(got.parse_status), 64'(e.parse_status));
        if (got.ip_version !== e.ip_version)
          report("version", 64'(got.ip_version), 64'(e.ip_version));
        if (got.protocol !== e.protocol)
          report("protocol", 64'(got.protocol), 64'(e.protocol));
        if (got.src_addr_hi !== e.src_addr_hi) report("src_hi", got.src_addr_hi, e.src_addr_hi);
        if (got.src_addr_lo !== e.src_addr_lo) report("src_lo", got.src_addr_lo, e.src_addr_lo);
        if (got.dst_addr_hi !== e.dst_addr_hi) report("dst_hi", got.dst_addr_hi, e.dst_addr_hi);
        if (got.dst_addr_lo !== e.dst_addr_lo) report("dst_lo", got.dst_addr_lo, e.dst_addr_lo);
        if (got.source_port !== e.source_port)
          report("sport", 64'(got.source_port), 64'(e.source_port));
        if (got.dest_port !== e.dest_port)
          report("dport", 64'(got.dest_port), 64'(e.dest_port));
        if (got.seq_ack !== e.seq_ack) report("seq_ack", got.seq_ack, e.seq_ack);
        if (got.transport_info !== e.transport_info)
          report("info", 64'(got.transport_info), 64'(e.transport_info));
        if (got.ip_total_length !== e.ip_total_length)
          report("length", 64'(got.ip_total_length), 64'(e.ip_total_length));
      end
    end
    if (out_hold) out_stall <= 1'b1;
    else out_stall <= recv_idle && ($urandom_range(99) < 35);
  end

  task automatic send_word(logic [7:0] b, logic last);
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    parse_byte(b, last);
    bytes_sent++;
    if (send_idle) begin
      while ($urandom_range(99) < 35) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic send_packet(logic [7:0] pk[$]);
    foreach (pk[i]) send_word(pk[i], i == pk.size() - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (headers_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_link(logic v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    lt = v;
  endtask

  // build a packet; kind: 0 tcp 1 udp 2 icmp 3 v6 ext chain 4 other proto 5 bad version
  function automatic void build(ref logic [7:0] pk[$], input int kind, input bit v6,
                                input bit rnd_fields);
    int ihlw;
    logic [7:0] nh;
    pk.delete();
    if (lt == 1'b0) repeat (14) pk.push_back(8'($urandom));
    nh = kind == 0 ? ithp_pkg::PROTO_TCP : kind == 1 ? ithp_pkg::PROTO_UDP :
         kind == 2 ? (v6 ? ithp_pkg::PROTO_ICMP6 : ithp_pkg::PROTO_ICMP) : 8'($urandom);
    if (kind == 5) begin
      pk.push_back({4'($urandom_range(3)), 4'($urandom)});
      repeat ($urandom_range(4)) pk.push_back(8'($urandom));
      return;
    end
    if (!v6) begin
      ihlw = rnd_fields ? $urandom_range(15) : 5;
      pk.push_back({ithp_pkg::VER_4, 4'(ihlw)});
      for (int i = 1; i < 20; i++) pk.push_back(i == 9 ? nh : 8'($urandom));
      if (ihlw > 5) repeat ((ihlw - 5) * 4) pk.push_back(8'($urandom));
    end else begin
      pk.push_back({ithp_pkg::VER_6, 4'($urandom)});
      if (kind == 3) nh = 8'($urandom_range(1) ? 0 : 43);
      for (int i = 1; i < 40; i++) pk.push_back(i == 6 ? nh : 8'($urandom));
      if (kind == 3) begin
        for (int h = $urandom_range(1, 3); h > 0; h--) begin
          case ($urandom_range(5))
            0: nh = ithp_pkg::PROTO_TCP;
            1: nh = ithp_pkg::PROTO_UDP;
            2: nh = ithp_pkg::PROTO_ICMP6;
            3: nh = ithp_pkg::NH_FRAG;
            4: nh = ithp_pkg::NH_ESP;
            default: nh = h == 1 ? ithp_pkg::NH_NONE : 8'd60;
          endcase
          pk.push_back(nh);
          pk.push_back(8'($urandom_range(2)));
          repeat ((pk[pk.size() - 1] + 1) * 8 - 2) pk.push_back(8'($urandom));
        end
      end
    end
    repeat (16) pk.push_back(8'($urandom));
    repeat ($urandom_range(3)) pk.push_back(8'($urandom));
  endfunction

  task automatic test_directed();
    logic [7:0] pk[$];
    for (int k = 0; k <= 5; k++) begin
      build(pk, k, 1'b0, 1'b0);
      send_packet(pk);
      if (k != 5) begin
        build(pk, k, 1'b1, 1'b0);
        send_packet(pk);
      end
    end
    pk = '{8'hFF, 8'h00};
    send_packet(pk);
    build(pk, 0, 1'b0, 1'b0);
    pk[pk.size() - 9] = 8'hFF;
    send_packet(pk);
    build(pk, 0, 1'b1, 1'b0);
    pk = pk[0:pk.size() - 8];
    send_packet(pk);
    pk = '{8'h00};
    send_packet(pk);
  endtask

  task automatic test_random(int nbytes);
    logic [7:0] pk[$];
    int start;
    start = bytes_sent;
    while (bytes_sent - start < nbytes) begin
      build(pk, $urandom_range(5), 1'($urandom_range(1)), 1'b1);
      if ($urandom_range(9) == 0) begin
        pk = pk[0:$urandom_range(pk.size() - 1)];
        if ($urandom_range(1)) pk[$urandom_range(pk.size() - 1)] = 8'($urandom);
      end
      send_packet(pk);
    end
  endtask

  task automatic test_backpressure();
    logic [7:0] pk[$];
    fork
      begin
        out_hold <= 1'b1;
        repeat (60) @(posedge clk);
        out_hold <= 1'b0;
      end
    join_none
    for (int i = 0; i < 4; i++) begin
      build(pk, 2, 1'b0, 1'b0);
      pk = pk[0:$urandom_range(1, 3)];
      send_packet(pk);
    end
  endtask

  task automatic test_long_packet();
    logic [7:0] pk[$];
    build(pk, 0, 1'b0, 1'b0);
    repeat (40) pk.push_back(8'($urandom));
    send_packet(pk);
  endtask

  initial begin
    lt = 1'b0;
    clear_parse();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    set_link(1'b1);
    test_random(120);
    set_link(1'b0);
    test_backpressure();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    test_random(120);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    test_long_packet();
    drain();
    $display("covered %0d bytes, %0d headers, both link types, stalls", bytes_sent,
             results_seen);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
